// ===== hdl/mcr_pkg.sv =====
// shared types and constants of the midpoint circle rasterizer
package mcr_pkg;

  localparam int unsigned CoordW    = 12;
  localparam int unsigned RadiusW   = 10;
  localparam int unsigned DecW      = 14;
  localparam int unsigned ColorW    = 16;
  localparam int unsigned ColW      = 9;
  localparam int unsigned RowW      = 8;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgIndexW-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_RADIUS   = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_COLOR    = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_FILL     = 3'd4;

  typedef struct packed {
    logic [CoordW-1:0]  center_x;
    logic [CoordW-1:0]  center_y;
    logic [RadiusW-1:0] radius;
    logic [ColorW-1:0]  color;
    logic               fill;
  } cfg_t;

  typedef struct packed {
    logic [RadiusW-1:0] x;
    logic [RadiusW-1:0] y;
    logic               empty;
    logic               done;
  } job_t;

endpackage

// ===== hdl/mcr_front.sv =====
// front part: takes tick items, runs the midpoint iteration, queues jobs
module mcr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mcr_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  logic          restart_i,
  output logic          push_o,
  output mcr_pkg::job_t job_o
);
  import mcr_pkg::*;

  logic                   busy_q, busy_d;
  logic [RadiusW-1:0]     x_q, y_q, x_cur, y_cur;
  logic [DecW-1:0]        d_q, d_cur, d_next;
  logic                   active, empty, ok_next, done, d_neg;
  logic [DecW-1:0]        x4, y4;
  logic signed [CoordW-1:0] nx, ny;

  always_comb begin
    x_cur = restart_i ? '0 : x_q;
    y_cur = restart_i ? cfg_i.radius : y_q;
    d_cur = restart_i ? (DecW'(3) - {3'b000, cfg_i.radius, 1'b0}) : d_q;
    active = restart_i || busy_q;
    empty = cfg_i.fill ? !(x_cur <= y_cur) : !(x_cur < y_cur);
    x4 = {2'b00, x_cur, 2'b00};
    y4 = {2'b00, y_cur, 2'b00};
    d_neg = d_cur[DecW-1];
    d_next = d_neg ? (d_cur + x4 + DecW'(6)) : (d_cur + (x4 - y4) + DecW'(10));
    nx = $signed({2'b00, x_cur}) + CoordW'(1);
    ny = $signed({2'b00, y_cur}) - (d_neg ? CoordW'(0) : CoordW'(1));
    ok_next = cfg_i.fill ? (nx <= ny) : (nx < ny);
    done = empty || !ok_next;
    busy_d = busy_q;
    if (accept_i && active) begin
      busy_d = !done;
    end
  end

  assign push_o = accept_i && active;
  assign job_o = '{x: x_cur, y: y_cur, empty: empty, done: done};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      d_q    <= '0;
    end else begin
      busy_q <= busy_d;
      if (push_o && !empty) begin
        x_q <= nx[RadiusW-1:0];
        y_q <= ny[RadiusW-1:0];
        d_q <= d_next;
      end
    end
  end

endmodule

// ===== hdl/mcr_queue.sv =====
// short job queue between front and back
module mcr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcr_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mcr_pkg::job_t job_o
);
  import mcr_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/mcr_back.sv =====
// back part: expands a job into mirrored points or spans, clips, registers output
module mcr_back #(
  parameter int unsigned SCREEN_W = 320,
  parameter int unsigned SCREEN_H = 240
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mcr_pkg::cfg_t              cfg_i,
  input  logic                       job_valid_i,
  input  mcr_pkg::job_t              job_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mcr_pkg::ColW-1:0]   span_left_o,
  output logic [mcr_pkg::ColW-1:0]   span_right_o,
  output logic [mcr_pkg::RowW-1:0]   span_row_o,
  output logic [mcr_pkg::ColorW-1:0] span_color_o,
  output logic                       visible_o,
  output logic                       circle_done_o,
  output logic                       run_last_o
);
  import mcr_pkg::*;

  localparam int unsigned SW = CoordW + 1;
  localparam logic signed [SW-1:0] ScrW = SW'(SCREEN_W);
  localparam logic signed [SW-1:0] ScrH = SW'(SCREEN_H);

  logic [2:0]             k_q;
  logic                   fire, last, swap, row_neg, col_neg, vis;
  logic [RadiusW-1:0]     col_off, row_off;
  logic signed [SW-1:0]   cxe, cye, coff, roff, left, right, row, left_c, right_c;
  logic                   out_valid_q;
  logic [ColW-1:0]        left_q, right_q;
  logic [RowW-1:0]        row_q;
  logic [ColorW-1:0]      color_q;
  logic                   vis_q, done_q, last_q;

  always_comb begin
    if (job_i.empty) begin
      last = 1'b1;
    end else if (cfg_i.fill) begin
      last = (k_q == 3'd3);
    end else begin
      last = (k_q == 3'd7);
    end
    swap    = cfg_i.fill ? k_q[1] : k_q[2];
    row_neg = cfg_i.fill ? k_q[0] : k_q[1];
    col_neg = !cfg_i.fill && k_q[0];
    col_off = swap ? job_i.y : job_i.x;
    row_off = swap ? job_i.x : job_i.y;
    cxe  = $signed({cfg_i.center_x[CoordW-1], cfg_i.center_x});
    cye  = $signed({cfg_i.center_y[CoordW-1], cfg_i.center_y});
    coff = $signed({3'b000, col_off});
    roff = $signed({3'b000, row_off});
    if (cfg_i.fill) begin
      left  = cxe - coff;
      right = cxe + coff;
    end else begin
      left  = col_neg ? (cxe - coff) : (cxe + coff);
      right = left;
    end
    row = row_neg ? (cye - roff) : (cye + roff);
    vis = !job_i.empty && !row[SW-1] && (row < ScrH) && !right[SW-1] && (left < ScrW);
    left_c  = left[SW-1] ? '0 : left;
    right_c = (right > ScrW - SW'(1)) ? (ScrW - SW'(1)) : right;
  end

  assign fire  = job_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = fire && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        k_q <= last ? '0 : k_q + 3'd1;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      left_q  <= vis ? left_c[ColW-1:0] : '0;
      right_q <= vis ? right_c[ColW-1:0] : '0;
      row_q   <= vis ? row[RowW-1:0] : '0;
      color_q <= cfg_i.color;
      vis_q   <= vis;
      done_q  <= last && job_i.done;
      last_q  <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign span_left_o   = left_q;
  assign span_right_o  = right_q;
  assign span_row_o    = row_q;
  assign span_color_o  = color_q;
  assign visible_o     = vis_q;
  assign circle_done_o = done_q;
  assign run_last_o    = last_q;

endmodule

// ===== hdl/midpoint_circle_rasterizer.sv =====
// top level of the midpoint circle rasterizer
// usage:
// - write center, radius, color and fill mode through cfg_we_i / cfg_index_i /
//   cfg_data_i while the block is idle; a write takes effect at the next edge
// - each item on the input channel is one tick; restart_i = 1 starts a new circle
//   from the registers, restart_i = 0 advances the running circle by one iteration
// - a tick gives eight points (outline), four spans (fill), one invisible done item
//   (empty loop) or nothing (not busy), one result per cycle while out_ready_i is high
// - run_last_o marks the last result of a tick, circle_done_o the last of a circle
// a tick's job is stored in the job queue, its results in the output register
// throughput: one result per cycle while out_ready_i is high, set by the single output
//   register of the back part; an outline tick takes eight results, a fill tick four
// a two-entry job queue lets ticks be taken while the back part is still busy
// reset clears the registers, the iteration state, the job queue and out_valid_o
// when out_ready_i is low the output item holds; the queue fills and then
//   in_ready_o drops until the back part moves again
module midpoint_circle_rasterizer #(
  parameter int unsigned SCREEN_W = 320,
  parameter int unsigned SCREEN_H = 240
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcr_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [mcr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mcr_pkg::ColW-1:0]      span_left_o,
  output logic [mcr_pkg::ColW-1:0]      span_right_o,
  output logic [mcr_pkg::RowW-1:0]      span_row_o,
  output logic [mcr_pkg::ColorW-1:0]    span_color_o,
  output logic                          visible_o,
  output logic                          circle_done_o,
  output logic                          run_last_o
);
  import mcr_pkg::*;

  cfg_t cfg_q;
  job_t push_job, head_job;
  logic accept, push, full, pop, head_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CENTER_X: cfg_q.center_x <= cfg_data_i[CoordW-1:0];
        REG_CENTER_Y: cfg_q.center_y <= cfg_data_i[CoordW-1:0];
        REG_RADIUS:   cfg_q.radius   <= cfg_data_i[RadiusW-1:0];
        REG_COLOR:    cfg_q.color    <= cfg_data_i[ColorW-1:0];
        REG_FILL:     cfg_q.fill     <= cfg_data_i[0];
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  mcr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .restart_i (restart_i),
    .push_o    (push),
    .job_o     (push_job)
  );

  mcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  mcr_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .job_valid_i   (head_valid),
    .job_i         (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .span_left_o   (span_left_o),
    .span_right_o  (span_right_o),
    .span_row_o    (span_row_o),
    .span_color_o  (span_color_o),
    .visible_o     (visible_o),
    .circle_done_o (circle_done_o),
    .run_last_o    (run_last_o)
  );

endmodule

// ===== hdl/mcr_checker.sv =====
// port-level checks of the midpoint circle rasterizer, bound to the top level
module mcr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          restart_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [mcr_pkg::ColW-1:0]      span_left_o,
  input logic [mcr_pkg::ColW-1:0]      span_right_o,
  input logic [mcr_pkg::RowW-1:0]      span_row_o,
  input logic [mcr_pkg::ColorW-1:0]    span_color_o,
  input logic                          visible_o,
  input logic                          circle_done_o,
  input logic                          run_last_o
);

  // offered tick held until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(restart_i))
    else $error("input item changed while waiting");

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(span_left_o) && $stable(span_right_o)
      && $stable(span_row_o) && $stable(span_color_o) && $stable(visible_o)
      && $stable(circle_done_o) && $stable(run_last_o))
    else $error("output item changed while stalled");

  // circle end only on the last result of a tick
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && circle_done_o |-> run_last_o)
    else $error("circle done without run last");

  // discarded items carry zero coordinates
  a_invisible_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> span_left_o == '0 && span_right_o == '0
      && span_row_o == '0)
    else $error("invisible item with nonzero coordinates");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (.*);

// ===== test/midpoint_circle_rasterizer_test.sv =====
// self-checking testbench for the midpoint circle rasterizer with its own span predictor
module midpoint_circle_rasterizer_test;
  import mcr_pkg::*;

  localparam int ScreenW = 320;
  localparam int ScreenH = 240;
  localparam int StallLimit = 1000;
  localparam int HoldCycles = 150;
  localparam int SettleCycles = 12;
  localparam int RandomTicks = 80;

  typedef struct packed {
    logic [ColW-1:0]   left;
    logic [ColW-1:0]   right;
    logic [RowW-1:0]   row;
    logic [ColorW-1:0] color;
    logic              vis;
    logic              done;
    logic              last;
  } span_t;

  class circle_tracker;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic [RadiusW-1:0]       radius;
    logic [ColorW-1:0]        color;
    logic                     fill;
    bit                       busy;
    logic [RadiusW-1:0]       x_pos;
    logic [RadiusW-1:0]       y_pos;
    logic signed [DecW-1:0]   err_term;
    span_t                    pending_spans[$];
    int                       bad_spans;

    function new();
      cx = '0;
      cy = '0;
      radius = '0;
      color = '0;
      fill = 1'b0;
      busy = 1'b0;
      x_pos = '0;
      y_pos = '0;
      err_term = '0;
      bad_spans = 0;
    endfunction

    function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_CENTER_X: cx = data[CoordW-1:0];
        REG_CENTER_Y: cy = data[CoordW-1:0];
        REG_RADIUS:   radius = data[RadiusW-1:0];
        REG_COLOR:    color = data[ColorW-1:0];
        REG_FILL:     fill = data[0];
        default: ;
      endcase
    endfunction

    function bit in_loop(int x, int y);
      return fill ? (x <= y) : (x < y);
    endfunction

    function span_t clip_span(int left, int right, int row);
      span_t s;
      s = '0;
      s.color = color;
      s.vis = row >= 0 && row < ScreenH && right >= 0 && left < ScreenW;
      if (s.vis) begin
        if (left < 0) left = 0;
        if (right > ScreenW - 1) right = ScreenW - 1;
        s.left = ColW'(left);
        s.right = ColW'(right);
        s.row = RowW'(row);
      end
      return s;
    endfunction

    function void take_tick(logic restart);
      span_t run[8];
      int n, ox, oy, x, y, d, nx, ny;
      n = 0;
      if (restart) begin
        busy = 1'b1;
        x_pos = '0;
        y_pos = radius;
        err_term = DecW'(3 - 2 * int'(radius));
      end
      if (!busy) return;
      ox = int'(cx);
      oy = int'(cy);
      x = int'(x_pos);
      y = int'(y_pos);
      d = int'(err_term);
      if (!in_loop(x, y)) begin
        run[0] = clip_span(-1, -1, -1);
        run[0].done = 1'b1;
        run[0].last = 1'b1;
        n = 1;
        busy = 1'b0;
      end else begin
        if (fill) begin
          run[0] = clip_span(ox - x, ox + x, oy + y);
          run[1] = clip_span(ox - x, ox + x, oy - y);
          run[2] = clip_span(ox - y, ox + y, oy + x);
          run[3] = clip_span(ox - y, ox + y, oy - x);
          n = 4;
        end else begin
          run[0] = clip_span(ox + x, ox + x, oy + y);
          run[1] = clip_span(ox - x, ox - x, oy + y);
          run[2] = clip_span(ox + x, ox + x, oy - y);
          run[3] = clip_span(ox - x, ox - x, oy - y);
          run[4] = clip_span(ox + y, ox + y, oy + x);
          run[5] = clip_span(ox - y, ox - y, oy + x);
          run[6] = clip_span(ox + y, ox + y, oy - x);
          run[7] = clip_span(ox - y, ox - y, oy - x);
          n = 8;
        end
        ny = y;
        if (d < 0) begin
          d = d + 4 * x + 6;
        end else begin
          d = d + 4 * (x - y) + 10;
          ny = y - 1;
        end
        nx = x + 1;
        if (!in_loop(nx, ny)) begin
          run[n-1].done = 1'b1;
          busy = 1'b0;
        end
        run[n-1].last = 1'b1;
        x_pos = RadiusW'(nx);
        y_pos = RadiusW'(ny);
        err_term = DecW'(d);
      end
      for (int i = 0; i < n; i++) pending_spans.push_back(run[i]);
    endfunction

    function void match_span(span_t got);
      span_t want;
      if (pending_spans.size() == 0) begin
        bad_spans++;
        if (bad_spans <= 10)
          $display("unexpected span: l=%0d r=%0d row=%0d color=%h vis=%b done=%b last=%b",
                   got.left, got.right, got.row, got.color, got.vis, got.done, got.last);
        return;
      end
      want = pending_spans.pop_front();
      if (got.left !== want.left || got.right !== want.right || got.row !== want.row ||
          got.color !== want.color || got.vis !== want.vis || got.done !== want.done ||
          got.last !== want.last) begin
        bad_spans++;
        if (bad_spans <= 10) begin
          $display("span mismatch: expected l=%0d r=%0d row=%0d color=%h vis=%b done=%b last=%b",
                   want.left, want.right, want.row, want.color, want.vis, want.done,
                   want.last);
          $display("               actual   l=%0d r=%0d row=%0d color=%h vis=%b done=%b last=%b",
                   got.left, got.right, got.row, got.color, got.vis, got.done, got.last);
        end
      end
    endfunction

    function int pending();
      return pending_spans.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 restart_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [ColW-1:0]      span_left_o;
  logic [ColW-1:0]      span_right_o;
  logic [RowW-1:0]      span_row_o;
  logic [ColorW-1:0]    span_color_o;
  logic                 visible_o;
  logic                 circle_done_o;
  logic                 run_last_o;

  circle_tracker tracker = new();
  bit steady = 1'b0;
  bit no_idle = 1'b0;
  bit long_hold = 1'b0;
  int quiet_cycles = 0;

  midpoint_circle_rasterizer #(
    .SCREEN_W(ScreenW),
    .SCREEN_H(ScreenH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .span_left_o  (span_left_o),
    .span_right_o (span_right_o),
    .span_row_o   (span_row_o),
    .span_color_o (span_color_o),
    .visible_o    (visible_o),
    .circle_done_o(circle_done_o),
    .run_last_o   (run_last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.match_span('{left: span_left_o, right: span_right_o, row: span_row_o,
                           color: span_color_o, vis: visible_o, done: circle_done_o,
                           last: run_last_o});
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles > StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    wait (rst_ni);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  task automatic set_circle(input int cx, input int cy, input int r, input int color,
                            input logic fill);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    write_reg(REG_CENTER_X, {junk[CfgDataW-1:CoordW], CoordW'(cx)});
    write_reg(REG_CENTER_Y, {junk[CoordW-1:CoordW-(CfgDataW-CoordW)], CoordW'(cy)});
    write_reg(REG_RADIUS, {junk[CfgDataW-1:RadiusW], RadiusW'(r)});
    write_reg(REG_COLOR, ColorW'(color));
    write_reg(REG_FILL, {junk[CfgDataW-1:1], fill});
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_tick(input logic rs);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_tick(rs);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int work, phase, n, cx, cy, r, guard;
    logic fill, rs;
    work = 0;
    phase = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick, then outline with radius zero
    send_tick(1'b0);
    send_tick(1'b1);
    drain();

    set_circle(160, 120, 3, 16'hffff, 1'b0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();

    set_circle(0, 0, 0, 16'h0000, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();

    set_circle(-2048, 2047, 1023, 16'h5a5a, 1'b0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    drain();

    set_circle(2047, -2048, 1023, 16'ha5a5, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();

    set_circle(-3, 238, 12, 16'h07e0, 1'b1);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();

    // restart while a circle is running
    set_circle(317, 2, 12, 16'hf800, 1'b0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // fill mode dropped at the diagonal gives an empty loop
    set_circle(100, 100, 3, 16'h001f, 1'b1);
    send_tick(1'b1);
    guard = 0;
    while (tracker.busy && tracker.x_pos != tracker.y_pos && guard < 20) begin
      send_tick(1'b0);
      guard++;
    end
    drain();
    write_reg(REG_FILL, '0);
    cfg_we_i <= 1'b0;
    send_tick(1'b0);
    drain();

    while (work < RandomTicks) begin
      phase++;
      if (work >= RandomTicks - 25) begin
        no_idle = 1'b1;
        steady = 1'b1;
      end
      fill = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) r = int'($urandom_range(0, 1023));
      else r = int'($urandom_range(0, 24));
      if ($urandom_range(0, 5) == 0) begin
        cx = int'($urandom_range(0, 4095)) - 2048;
        cy = int'($urandom_range(0, 4095)) - 2048;
      end else begin
        cx = int'($urandom_range(0, 400)) - 40;
        cy = int'($urandom_range(0, 320)) - 40;
      end
      n = int'($urandom_range(3, 12));
      if (phase == 2) begin
        cx = 160;
        cy = 120;
        r = 40;
        fill = 1'b0;
        n = 14;
        steady = 1'b1;
      end
      set_circle(cx, cy, r, int'($urandom_range(0, 65535)), fill);
      if (phase == 2) long_hold = 1'b1;
      send_tick(1'b1);
      work++;
      for (int i = 0; i < n; i++) begin
        rs = ($urandom_range(0, 11) == 0);
        if (rs || tracker.busy) work++;
        send_tick(rs);
      end
      drain();
      steady = no_idle;
      if (tracker.busy && $urandom_range(0, 3) == 0) begin
        write_reg(REG_FILL, CfgDataW'(!tracker.fill));
        cfg_we_i <= 1'b0;
        repeat (2) begin
          if (tracker.busy) work++;
          send_tick(1'b0);
        end
        drain();
      end
    end

    drain();
    if (tracker.bad_spans == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
